// ----- sv/atrm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AT response matcher package
// Shared constants, response codes and back-end state type.
// ---------------------------------------------------------------------------
package atrm_pkg;

   // Default line store depth in bytes.
   localparam int STORE_DEPTH_DEF = 256;

   // Reset value of the payload signature register.
   localparam logic [47:0] SIG_RESET = 48'h536D_8C1A_1032;

   // Patterns, first byte most significant.
   localparam logic [47:0] PAT_READ = 48'h2B52_4541_443D;  // "+READ="
   localparam logic [47:0] PAT_ERR  = 48'h2B45_5252_4F52;  // "+ERROR"
   localparam logic [15:0] PAT_OK   = 16'h4F4B;            // "OK"

   localparam int HDR_LEN    = 6;
   localparam int OK_LEN     = 2;
   localparam int ERR_LEN    = 6;
   localparam int READ_TOTAL = 24;

   // Response codes.
   typedef enum logic [2:0] {
      RESP_NONE    = 3'd0,
      RESP_READ    = 3'd1,
      RESP_OK      = 3'd2,
      RESP_ERROR   = 3'd3,
      RESP_UNKNOWN = 3'd4
   } resp_type;

   // Back-end sequencer states.
   typedef enum logic [3:0] {
      B_IDLE,
      B_SCAN_RD,
      B_SCAN_CHK,
      B_SCAN_END,
      B_PAY_RD,
      B_PAY_CHK,
      B_MOVE_RD,
      B_MOVE_WR,
      B_RESULT
   } back_state_type;

endpackage

// ----- sv/atrm_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module atrm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Storage array and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/atrm_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Small FIFO
// Register-based queue used between the front end, back end and outputs.
// ---------------------------------------------------------------------------
module atrm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rptr_ff];

   // Pointer and count update.
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/atrm_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AT response matcher front end
// Stores received bytes, tracks the open chunk and issues analysis jobs.
// ---------------------------------------------------------------------------
module atrm_front
   import atrm_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic [7:0]                     req_rx_byte,
   input  logic                           req_chunk_end,
   output logic                           req_full,
   output logic                           ram_we,
   output logic [$clog2(STORE_DEPTH)-1:0] ram_waddr,
   output logic [7:0]                     ram_wdata,
   output logic                           job_push,
   output logic [$clog2(STORE_DEPTH+1)-1:0] job_fill,
   input  logic                           done_valid,
   input  logic [$clog2(STORE_DEPTH+1)-1:0] done_fill
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);

   logic [CW-1:0] fill_ff, fill_in, pend_ff, pend_in, pend_inc;
   logic          busy_ff, busy_in;
   logic [CW:0]   pos, total;
   logic          accept;

   assign accept   = req_push && !busy_ff;
   assign req_full = busy_ff;
   assign pos      = {1'b0, fill_ff} + {1'b0, pend_ff};
   assign pend_inc = (pend_ff < CW'(STORE_DEPTH)) ? pend_ff + 1'b1 : pend_ff;
   assign total    = {1'b0, fill_ff} + {1'b0, pend_inc};

   // Byte write into the line store while it fits.
   assign ram_we    = accept && (pos < (CW + 1)'(STORE_DEPTH));
   assign ram_waddr = pos[AW-1:0];
   assign ram_wdata = req_rx_byte;

   // A chunk end commits or drops the store and hands off a job.
   assign job_push = accept && req_chunk_end;
   assign job_fill = (total < (CW + 1)'(STORE_DEPTH - 1)) ? total[CW-1:0] : '0;

   always_comb begin
      fill_in = fill_ff;
      pend_in = pend_ff;
      busy_in = busy_ff;
      if (accept) begin
         if (req_chunk_end) begin
            pend_in = '0;
            busy_in = 1'b1;
         end else begin
            pend_in = pend_inc;
         end
      end
      if (done_valid) begin
         fill_in = done_fill;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pend_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         pend_ff <= pend_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ----- sv/atrm_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AT response matcher back end
// Scans the committed line, checks read payloads and shifts out used bytes.
// ---------------------------------------------------------------------------
module atrm_back
   import atrm_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [47:0]                      signature,
   input  logic                             job_empty,
   input  logic [$clog2(STORE_DEPTH+1)-1:0] job_fill,
   output logic                             job_pop,
   output logic [$clog2(STORE_DEPTH)-1:0]   ram_raddr,
   input  logic [7:0]                       ram_rdata,
   output logic                             ram_we,
   output logic [$clog2(STORE_DEPTH)-1:0]   ram_waddr,
   output logic [7:0]                       ram_wdata,
   input  logic                             res_full,
   output logic                             res_push,
   output logic [2:0]                       res_code,
   output logic                             done_valid,
   output logic [$clog2(STORE_DEPTH+1)-1:0] done_fill
);

   localparam int AW        = $clog2(STORE_DEPTH);
   localparam int CW        = $clog2(STORE_DEPTH + 1);
   localparam int FULL_MARK = STORE_DEPTH * 3 / 4;

   back_state_type state_ff, state_in;
   logic [CW-1:0]  fill_ff, fill_in, idx_ff, idx_in, cons_ff, cons_in;
   logic [CW-1:0]  rd_off_ff, rd_off_in, ok_off_ff, ok_off_in, err_off_ff, err_off_in;
   logic           ok_hit_ff, ok_hit_in, err_hit_ff, err_hit_in, miss_ff, miss_in;
   logic [47:0]    win_ff, win_in;
   resp_type       code_ff, code_in;
   logic [47:0]    win_next;
   logic [CW-1:0]  rest, rd_off_new;
   logic [CW:0]    read_end;
   logic [2:0]     sel;
   logic [7:0]     want;

   assign win_next   = {win_ff[39:0], ram_rdata};
   assign rd_off_new = idx_ff - CW'(HDR_LEN - 1);
   assign read_end   = {1'b0, rd_off_new} + (CW + 1)'(READ_TOTAL);
   assign rest       = fill_ff - cons_ff;
   assign sel        = 3'(HDR_LEN - 1) - idx_ff[2:0];
   assign want       = signature[8 * sel +: 8];

   // Sequencer next state and datapath control.
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      idx_in     = idx_ff;
      cons_in    = cons_ff;
      rd_off_in  = rd_off_ff;
      ok_off_in  = ok_off_ff;
      err_off_in = err_off_ff;
      ok_hit_in  = ok_hit_ff;
      err_hit_in = err_hit_ff;
      miss_in    = miss_ff;
      win_in     = win_ff;
      code_in    = code_ff;
      job_pop    = 1'b0;
      ram_raddr  = idx_ff[AW-1:0];
      ram_we     = 1'b0;
      ram_waddr  = idx_ff[AW-1:0];
      ram_wdata  = ram_rdata;
      res_push   = 1'b0;
      done_valid = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_pop    = 1'b1;
               fill_in    = job_fill;
               idx_in     = '0;
               win_in     = '0;
               ok_hit_in  = 1'b0;
               err_hit_in = 1'b0;
               miss_in    = 1'b0;
               code_in    = RESP_NONE;
               state_in   = B_SCAN_RD;
            end
         end
         B_SCAN_RD: begin
            if (idx_ff >= fill_ff) begin
               state_in = B_SCAN_END;
            end else begin
               state_in = B_SCAN_CHK;
            end
         end
         B_SCAN_CHK: begin
            if (ram_rdata == 8'h00) begin
               state_in = B_SCAN_END;
            end else if (win_next == PAT_READ) begin
               // Read header found: it wins over everything else.
               rd_off_in = rd_off_new;
               idx_in    = '0;
               if ({1'b0, fill_ff} >= read_end) begin
                  state_in = B_PAY_RD;
               end else begin
                  code_in  = RESP_NONE;
                  state_in = B_RESULT;
               end
            end else begin
               win_in = win_next;
               if (!ok_hit_ff && win_next[15:0] == PAT_OK) begin
                  ok_hit_in = 1'b1;
                  ok_off_in = idx_ff - CW'(OK_LEN - 1);
               end
               if (!err_hit_ff && win_next == PAT_ERR) begin
                  err_hit_in = 1'b1;
                  err_off_in = idx_ff - CW'(ERR_LEN - 1);
               end
               idx_in   = idx_ff + 1'b1;
               state_in = B_SCAN_RD;
            end
         end
         B_SCAN_END: begin
            idx_in   = '0;
            state_in = B_MOVE_RD;
            if (ok_hit_ff) begin
               code_in = RESP_OK;
               cons_in = ok_off_ff + CW'(OK_LEN);
            end else if (err_hit_ff) begin
               code_in = RESP_ERROR;
               cons_in = err_off_ff + CW'(ERR_LEN);
            end else if (fill_ff > CW'(FULL_MARK)) begin
               code_in = RESP_UNKNOWN;
               cons_in = fill_ff;
            end else begin
               code_in  = RESP_NONE;
               state_in = B_RESULT;
            end
         end
         B_PAY_RD: begin
            ram_raddr = AW'(rd_off_ff + CW'(HDR_LEN) + idx_ff);
            state_in  = B_PAY_CHK;
         end
         B_PAY_CHK: begin
            if (idx_ff == CW'(HDR_LEN - 1)) begin
               code_in  = (miss_ff || ram_rdata != want) ? RESP_UNKNOWN : RESP_READ;
               cons_in  = rd_off_ff + CW'(READ_TOTAL);
               idx_in   = '0;
               state_in = B_MOVE_RD;
            end else begin
               miss_in  = miss_ff || (ram_rdata != want);
               idx_in   = idx_ff + 1'b1;
               state_in = B_PAY_RD;
            end
         end
         B_MOVE_RD: begin
            // Copy the unconsumed tail down to the start of the store.
            ram_raddr = AW'(cons_ff + idx_ff);
            if (idx_ff >= rest) begin
               fill_in  = rest;
               state_in = B_RESULT;
            end else begin
               state_in = B_MOVE_WR;
            end
         end
         B_MOVE_WR: begin
            ram_we   = 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = B_MOVE_RD;
         end
         B_RESULT: begin
            if (!res_full) begin
               res_push   = 1'b1;
               done_valid = 1'b1;
               state_in   = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign res_code  = code_ff;
   assign done_fill = fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff    <= fill_in;
      idx_ff     <= idx_in;
      cons_ff    <= cons_in;
      rd_off_ff  <= rd_off_in;
      ok_off_ff  <= ok_off_in;
      err_off_ff <= err_off_in;
      ok_hit_ff  <= ok_hit_in;
      err_hit_ff <= err_hit_in;
      miss_ff    <= miss_in;
      win_ff     <= win_in;
      code_ff    <= code_in;
   end

   // The store is only written back during the tail copy.
   a_we_move: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == B_MOVE_WR)
      else $error("back end wrote the store outside the tail copy");

   // A finished job returns to idle in the next cycle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_valid |=> state_ff == B_IDLE)
      else $error("back end did not return to idle after a job");

   // Consumed bytes never exceed the committed fill.
   a_cons_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_MOVE_RD) |-> cons_ff <= fill_ff)
      else $error("consumed count beyond fill length");

endmodule

// ----- sv/at_response_matcher.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AT response matcher
// Collects UART bytes and reports the modem response found at chunk ends.
// ---------------------------------------------------------------------------
// A byte without the chunk end flag is accepted at once while req_full is
// low. A byte that ends a chunk starts an analysis pass, and req_full stays
// high until it finishes: the pass scans the stored bytes up to the first
// zero or the fill, checks a read payload, and shifts the unconsumed tail
// down after a match. The line store has a single read port. One response
// transaction comes out per chunk end.
module at_response_matcher
   import atrm_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_chunk_end,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_response_code,
   input  logic        csr_write_enable,
   input  logic [47:0] csr_write_data
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);

   logic [47:0]   sig_ff;
   logic          f_we, b_we, ram_we;
   logic [AW-1:0] f_waddr, b_waddr, ram_waddr, ram_raddr;
   logic [7:0]    f_wdata, b_wdata, ram_wdata, ram_rdata;
   logic          job_push, job_pop, job_empty, job_full_unused;
   logic [CW-1:0] job_fill_in, job_fill_out, done_fill;
   logic          done_valid, res_push, res_full;
   logic [2:0]    res_code;

   // Signature register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sig_ff <= SIG_RESET;
      end else if (csr_write_enable) begin
         sig_ff <= csr_write_data;
      end
   end

   atrm_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
      .clock, .reset, .req_push, .req_rx_byte, .req_chunk_end, .req_full,
      .ram_we(f_we), .ram_waddr(f_waddr), .ram_wdata(f_wdata),
      .job_push, .job_fill(job_fill_in), .done_valid, .done_fill
   );

   atrm_fifo #(.WIDTH(CW), .DEPTH(2)) u_job_q (
      .clock, .reset, .push(job_push), .push_data(job_fill_in),
      .full(job_full_unused), .pop(job_pop), .pop_data(job_fill_out),
      .empty(job_empty)
   );

   atrm_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
      .clock, .reset, .signature(sig_ff), .job_empty, .job_fill(job_fill_out),
      .job_pop, .ram_raddr, .ram_rdata, .ram_we(b_we), .ram_waddr(b_waddr),
      .ram_wdata(b_wdata), .res_full, .res_push, .res_code, .done_valid,
      .done_fill
   );

   // The front end writes only while no job is open, the back end only during one.
   assign ram_we    = f_we | b_we;
   assign ram_waddr = b_we ? b_waddr : f_waddr;
   assign ram_wdata = b_we ? b_wdata : f_wdata;

   atrm_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
      .clock, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   atrm_fifo #(.WIDTH(3), .DEPTH(2)) u_rsp_q (
      .clock, .reset, .push(res_push), .push_data(res_code), .full(res_full),
      .pop(rsp_pop), .pop_data(rsp_response_code), .empty(rsp_empty)
   );

endmodule
